/* rtl/core/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and helpers for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

   localparam int INPUT_WIDTH_DEFAULT = 32;

   // Magnitude bits folded into the BCD register per conversion cycle.
   localparam int BITS_PER_CYCLE = 4;

   // Depth of the queue between the converter and the character emitter.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Decimal digits needed for any value below 2^width: floor(width*log10(2))+1.
   function automatic int num_digits(input int width);
      return ((width * 1233) >> 12) + 1;
   endfunction

   // Width of a digit index, never below one bit.
   function automatic int index_width(input int width);
      return (num_digits(width) > 1) ? $clog2(num_digits(width)) : 1;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/sitda_front.sv */
// ----------------------------------------------------------------------------
// sitda_front
// Accepts a value, splits off the sign and turns the magnitude into packed
// BCD with a shift-and-add-3 loop, several bits per cycle, then hands the
// sign, the digits and the position of the leading digit to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_front #(
   parameter int INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [INPUT_WIDTH-1:0] req_value,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output logic [1 + sitda_pkg::index_width(INPUT_WIDTH)
                 + 4 * sitda_pkg::num_digits(INPUT_WIDTH) - 1:0] push_data
);
   import sitda_pkg::*;

   localparam int NDIG   = num_digits(INPUT_WIDTH);
   localparam int IDX_W  = index_width(INPUT_WIDTH);
   localparam int BCD_W  = 4 * NDIG;
   localparam int PAD_W  = ((INPUT_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE)
                           * BITS_PER_CYCLE;
   localparam int STEPS  = PAD_W / BITS_PER_CYCLE;
   localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [PAD_W-1:0]       mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;

   logic [INPUT_WIDTH-1:0] magnitude;
   logic [BCD_W-1:0]       bcd_step;
   logic [PAD_W-1:0]       mag_step;
   logic [IDX_W-1:0]       lead_idx;
   logic                   accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Two's complement negation is taken as unsigned, so the most negative
   // value yields its true magnitude.
   assign magnitude = req_value[INPUT_WIDTH-1] ? (~$unsigned(req_value) + 1'b1)
                                               : $unsigned(req_value);

   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < BITS_PER_CYCLE; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], mag_step[PAD_W-1]};
         mag_step = {mag_step[PAD_W-2:0], 1'b0};
      end
   end

   // The highest nonzero digit; zero leaves the index at the units digit.
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = IDX_W'(d);
         end
      end
   end

   assign push_valid = (state_ff == ST_PUSH);
   assign push_data  = {neg_ff, lead_idx, bcd_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
               cnt_in   = CNT_W'(STEPS - 1);
               neg_in   = req_value[INPUT_WIDTH-1];
               mag_in   = PAD_W'(magnitude);
               bcd_in   = '0;
            end
         end
         ST_CONV: begin
            mag_in = mag_step;
            bcd_in = bcd_step;
            if (cnt_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

endmodule

`default_nettype wire

/* rtl/core/sitda_queue.sv */
// ----------------------------------------------------------------------------
// sitda_queue
// Short first-in first-out queue of converted numbers between the converter
// and the character emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic                   rd_valid,
   input  wire logic              rd_pop,
   output logic [DATA_W-1:0]      rd_data
);
   import sitda_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_write;
   logic              do_read;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_write = wr_valid && wr_ready;
   assign do_read  = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sitda_back.sv */
// ----------------------------------------------------------------------------
// sitda_back
// Takes converted numbers from the queue and sends their text one character
// a cycle: the minus sign if any, then the digits from the leading one down.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_back #(
   parameter int INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_pop,
   input  wire logic [1 + sitda_pkg::index_width(INPUT_WIDTH)
                      + 4 * sitda_pkg::num_digits(INPUT_WIDTH) - 1:0] q_data,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_character,
   output logic             rsp_last
);
   import sitda_pkg::*;

   localparam int NDIG    = num_digits(INPUT_WIDTH);
   localparam int IDX_W   = index_width(INPUT_WIDTH);
   localparam int BCD_W   = 4 * NDIG;
   localparam int ENTRY_W = 1 + IDX_W + BCD_W;

   logic             active_ff, active_in;
   logic             minus_ff, minus_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             strobe_ff, strobe_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;

   logic [3:0]       digit;
   logic             finishing;

   assign digit     = bcd_ff[idx_ff*4 +: 4];
   assign finishing = active_ff && !minus_ff && (idx_ff == '0);

   // The next number is loaded while the final character of the current one
   // goes out, so a waiting number follows the current one without a gap.
   assign q_pop = q_valid && (!active_ff || finishing);

   always_comb begin
      strobe_in = active_ff;
      char_in   = minus_ff ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
      last_in   = !minus_ff && (idx_ff == '0);

      active_in = active_ff;
      minus_in  = minus_ff;
      idx_in    = idx_ff;
      bcd_in    = bcd_ff;
      if (active_ff) begin
         if (minus_ff) begin
            minus_in = 1'b0;
         end else if (idx_ff != '0) begin
            idx_in = idx_ff - 1'b1;
         end else begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         active_in = 1'b1;
         minus_in  = q_data[ENTRY_W-1];
         idx_in    = q_data[BCD_W +: IDX_W];
         bcd_in    = q_data[BCD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      minus_ff <= minus_in;
      idx_ff   <= idx_in;
      bcd_ff   <= bcd_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its text leaves on the
// rsp_ ports one character per cycle, each beat marked by rsp_strobe for one
// cycle: a minus sign for negative values, then the digits most significant
// first, with rsp_last on the final digit. The receiver cannot stall, so beats
// must be taken as they come. The converter stays busy until it has converted
// the value and handed the number to a two-entry queue, and can then take the
// next value while the emitter sends the previous text. The emitter sends 1 to
// 11 characters per number at 32 bits, so whichever of the converter and the
// emitter is slower sets the sustained rate. After the conversion the number
// passes through the queue, the emitter's digit registers and its character
// register before its first character appears.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
   parameter int INPUT_WIDTH = sitda_pkg::INPUT_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [INPUT_WIDTH-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [7:0]                         rsp_character,
   output logic                               rsp_last
);
   import sitda_pkg::*;

   localparam int ENTRY_W = 1 + index_width(INPUT_WIDTH) + 4 * num_digits(INPUT_WIDTH);

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               q_valid;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_data;

   sitda_front #(
      .INPUT_WIDTH (INPUT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sitda_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_data),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_data)
   );

   sitda_back #(
      .INPUT_WIDTH (INPUT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_data        (q_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
